[design/tapid_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the turn angle PID regulator.
// Word layouts, register indexes, action codes and Q2.14 gains; no dependencies.
package tapid_pkg;

	// field and path widths
	localparam int ROT_W      = 20;
	localparam int ERR_W      = 21;
	localparam int DRV_W      = 8;
	localparam int SPD_W      = 7;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 14;
	localparam int SUM_W      = 38;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 1'd1;

	// action codes
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// drive limits
	localparam logic [SPD_W-1:0] MAX_SPEED_RST = 7'd127;
	localparam logic [SPD_W-1:0] LIMIT_FLOOR   = 7'd50;
	localparam logic [SPD_W-1:0] MIN_DRIVE     = 7'd10;

	// gains in Q2.14
	localparam logic signed [GAIN_W-1:0] KP_BASE = 16'sd9830;
	localparam logic signed [GAIN_W-1:0] KP_NEAR = 16'sd19661;
	localparam logic signed [GAIN_W-1:0] KP_FAR  = 16'sd7864;
	localparam logic signed [7:0]        KI_Q    = 8'sd33;
	localparam logic signed [12:0]       KD_Q    = 13'sd2458;

	typedef struct packed {
		logic                    action;
		logic signed [ROT_W-1:0] rotation;
		logic                    rotation_valid;
	} tapid_in_t;

	typedef struct packed {
		logic signed [DRV_W-1:0] left_drive;
		logic signed [DRV_W-1:0] right_drive;
		logic                    done_res;
	} tapid_out_t;

	// decisions handed from the error stage to the drive stage
	typedef struct packed {
		logic force_zero;
		logic done;
	} tapid_ctl_t;

endpackage

[design/tapid_err_stage.sv]
`timescale 1ns / 1ps
// Error stage: set point, gain scheduling, integral and derivative, PID products.
// Holds the regulator state and the second pipeline register; uses tapid_pkg.
module tapid_err_stage #(
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   advance,
	input  logic                                   valid_s1,
	input  tapid_pkg::tapid_in_t                   item_s1,
	input  logic signed [tapid_pkg::ROT_W-1:0]     target_angle,
	input  logic [tapid_pkg::SPD_W-1:0]            max_speed,
	output tapid_pkg::tapid_ctl_t                  ctl_s2,
	output logic [tapid_pkg::SPD_W-1:0]            limit_s2,
	output logic signed [tapid_pkg::SUM_W-1:0]     p_kp_s2,
	output logic signed [tapid_pkg::SUM_W-1:0]     p_ki_s2,
	output logic signed [tapid_pkg::SUM_W-1:0]     p_kd_s2
);
	import tapid_pkg::*;

	localparam int DEG     = 1 << ANGLE_FRAC_BITS;
	localparam int INT_MAX = 100 * DEG;
	localparam int INT_W   = $clog2(INT_MAX + 1) + 1;

	localparam logic [ERR_W-1:0] ONE_DEG  = ERR_W'(DEG);
	localparam logic [ERR_W-1:0] WIND_LIM = ERR_W'(20 * DEG);
	localparam logic [ERR_W-1:0] NEAR_LIM = ERR_W'(45 * DEG);
	localparam logic [ERR_W-1:0] FAR_LIM  = ERR_W'(135 * DEG);
	localparam logic signed [INT_W-1:0] INT_HI = INT_W'(INT_MAX);
	localparam logic signed [INT_W-1:0] INT_LO = INT_W'(-INT_MAX);

	logic signed [INT_W-1:0]  integral_q;
	logic signed [ERR_W-1:0]  last_err_q;
	logic                     finished_q;

	logic signed [ERR_W-1:0]  setp;
	logic [ERR_W-1:0]         setp_abs;
	logic signed [ERR_W-1:0]  meas;
	logic signed [ERR_W:0]    diff;
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         err_abs;
	logic                     near, far;
	logic [SPD_W-1:0]         half_speed, sched_lim, limit;
	logic signed [GAIN_W-1:0] kp;
	logic                     is_start, small_err, windup_ok;
	logic signed [INT_W:0]    int_sum;
	logic signed [INT_W-1:0]  int_clamped, integral_d;
	logic signed [ERR_W:0]    deriv;
	logic signed [GAIN_W+ERR_W-1:0] kp_prod;
	logic signed [INT_W+7:0]        ki_prod;
	logic signed [ERR_W+13:0]       kd_prod;
	tapid_ctl_t               ctl_d;

	// set point and measured angle, error saturated to its field width
	assign setp     = -{target_angle[ROT_W-1], target_angle};
	assign setp_abs = setp[ERR_W-1] ? -setp : setp;
	assign meas     = item_s1.rotation_valid ?
		{item_s1.rotation[ROT_W-1], item_s1.rotation} : '0;
	assign diff     = {setp[ERR_W-1], setp} - {meas[ERR_W-1], meas};

	always_comb begin
		if (diff[ERR_W] != diff[ERR_W-1]) begin
			err = diff[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
		end else begin
			err = diff[ERR_W-1:0];
		end
	end

	assign err_abs = err[ERR_W-1] ? -err : err;

	// schedule gain and drive limit from the set point magnitude
	assign near       = setp_abs <= NEAR_LIM;
	assign far        = setp_abs > FAR_LIM;
	assign half_speed = {1'b0, max_speed[SPD_W-1:1]};
	assign sched_lim  = (half_speed > LIMIT_FLOOR) ? half_speed : LIMIT_FLOOR;
	assign limit      = (near || far) ? sched_lim : max_speed;
	assign kp         = near ? KP_NEAR : (far ? KP_FAR : KP_BASE);

	// integral with reset above the windup band and clamp
	assign is_start  = item_s1.action == ACT_START;
	assign small_err = err_abs < ONE_DEG;
	assign windup_ok = err_abs <= WIND_LIM;
	assign int_sum   = {integral_q[INT_W-1], integral_q} + err[INT_W:0];

	always_comb begin
		if (int_sum > INT_HI) begin
			int_clamped = INT_HI;
		end else if (int_sum < INT_LO) begin
			int_clamped = INT_LO;
		end else begin
			int_clamped = int_sum[INT_W-1:0];
		end
	end

	assign integral_d = windup_ok ? int_clamped : '0;
	assign deriv      = {err[ERR_W-1], err} - {last_err_q[ERR_W-1], last_err_q};

	// three independent products, registered before the sum
	assign kp_prod = kp * err;
	assign ki_prod = KI_Q * integral_d;
	assign kd_prod = KD_Q * deriv;

	always_comb begin
		ctl_d.done       = !is_start && (finished_q || small_err);
		ctl_d.force_zero = is_start || ctl_d.done;
	end

	// regulator state: clear on start, hold once finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			last_err_q <= '0;
			finished_q <= 1'b0;
		end else if (advance && valid_s1) begin
			if (is_start) begin
				integral_q <= '0;
				last_err_q <= '0;
				finished_q <= 1'b0;
			end else if (!finished_q) begin
				if (small_err) begin
					finished_q <= 1'b1;
				end else begin
					integral_q <= integral_d;
					last_err_q <= err;
				end
			end
		end
	end

	// second stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2   <= ctl_d;
			limit_s2 <= limit;
			p_kp_s2  <= SUM_W'(kp_prod);
			p_ki_s2  <= SUM_W'(ki_prod);
			p_kd_s2  <= SUM_W'(kd_prod);
		end
	end

`ifndef SYNTHESIS
	a_integral_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		integral_q <= INT_HI && integral_q >= INT_LO)
		else $error("integral outside its clamp");

	a_finished_holds: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && !(advance && valid_s1 && item_s1.action == ACT_START)
		|=> $stable(integral_q) && $stable(last_err_q) && finished_q)
		else $error("state changed while finished");
`endif

endmodule

[design/tapid_drive_stage.sv]
`timescale 1ns / 1ps
// Drive stage: PID sum, truncation toward zero, minimum magnitude and limit clamp.
// Holds the result register; uses tapid_pkg.
module tapid_drive_stage #(
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic                               clk,
	input  logic                               advance,
	input  tapid_pkg::tapid_ctl_t              ctl_s2,
	input  logic [tapid_pkg::SPD_W-1:0]        limit_s2,
	input  logic signed [tapid_pkg::SUM_W-1:0] p_kp_s2,
	input  logic signed [tapid_pkg::SUM_W-1:0] p_ki_s2,
	input  logic signed [tapid_pkg::SUM_W-1:0] p_kd_s2,
	output tapid_pkg::tapid_out_t              drive_q
);
	import tapid_pkg::*;

	localparam int SHIFT = GAIN_FRAC + ANGLE_FRAC_BITS;

	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        sum_abs, mag_full, mag_min;
	logic                    positive;
	logic [SPD_W-1:0]        mag;
	logic signed [DRV_W-1:0] right;
	tapid_out_t              drive_d;

	// sign and magnitude of the truncated control value
	assign sum      = p_kp_s2 + p_ki_s2 + p_kd_s2;
	assign sum_abs  = sum[SUM_W-1] ? -sum : sum;
	assign mag_full = sum_abs >> SHIFT;
	assign positive = !sum[SUM_W-1] && (mag_full != '0);

	// raise to the minimum magnitude, then clamp to the limit
	assign mag_min = (mag_full < SUM_W'(MIN_DRIVE)) ? SUM_W'(MIN_DRIVE) : mag_full;
	assign mag     = (mag_min > SUM_W'(limit_s2)) ? limit_s2 : mag_min[SPD_W-1:0];
	assign right   = positive ? $signed({1'b0, mag}) : -$signed({1'b0, mag});

	always_comb begin
		drive_d.done_res = ctl_s2.done;
		if (ctl_s2.force_zero) begin
			drive_d.right_drive = '0;
			drive_d.left_drive  = '0;
		end else begin
			drive_d.right_drive = right;
			drive_d.left_drive  = -right;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_d;
		end
	end

endmodule

[design/turn_angle_pid.sv]
`timescale 1ns / 1ps
// Turn angle PID regulator with gain scheduling and anti-windup.
// Throughput: one word per cycle while the result word is not stalled. The result word
// passes the input register, product register and result register in that order.
// A stalled result freezes the whole pipeline; the input stalls in the same cycle.
// Reset (arst_n low) clears the regulator state and valid flags, sets target 0, speed 127.
module turn_angle_pid #(
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  tapid_pkg::tapid_in_t                    sample,
	output logic                                    drive_valid,
	input  logic                                    drive_stall,
	output tapid_pkg::tapid_out_t                   drive,
	input  logic                                    cfg_write,
	input  logic [tapid_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tapid_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import tapid_pkg::*;

	logic signed [ROT_W-1:0] target_angle_q;
	logic [SPD_W-1:0]        max_speed_q;
	logic                    advance;
	logic                    valid_s1, valid_s2, drive_valid_q;
	tapid_in_t               item_s1;
	tapid_ctl_t              ctl_s2;
	logic [SPD_W-1:0]        limit_s2;
	logic signed [SUM_W-1:0] p_kp_s2, p_ki_s2, p_kd_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_angle_q <= '0;
			max_speed_q    <= MAX_SPEED_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TARGET_ANGLE: target_angle_q <= cfg_data[ROT_W-1:0];
				REG_MAX_SPEED:    max_speed_q    <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the pipeline unless the result word is held
	assign advance      = !(drive_valid_q && drive_stall);
	assign sample_stall = !advance;
	assign drive_valid  = drive_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			drive_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1      <= sample_valid;
			valid_s2      <= valid_s1;
			drive_valid_q <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= sample;
		end
	end

	tapid_err_stage #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.target_angle(target_angle_q),
		.max_speed   (max_speed_q),
		.ctl_s2      (ctl_s2),
		.limit_s2    (limit_s2),
		.p_kp_s2     (p_kp_s2),
		.p_ki_s2     (p_ki_s2),
		.p_kd_s2     (p_kd_s2)
	);

	tapid_drive_stage #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_drive (
		.clk     (clk),
		.advance (advance),
		.ctl_s2  (ctl_s2),
		.limit_s2(limit_s2),
		.p_kp_s2 (p_kp_s2),
		.p_ki_s2 (p_ki_s2),
		.p_kd_s2 (p_kd_s2),
		.drive_q (drive)
	);

`ifndef SYNTHESIS
	a_done_brakes: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive.done_res |-> drive.right_drive == '0 && drive.left_drive == '0)
		else $error("drive not zero while braking");

	a_drives_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive.left_drive == -drive.right_drive)
		else $error("left drive is not the negated right drive");
`endif

endmodule

[tb/tapid_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the turn angle PID regulator: predicts each drive word from the
// sample words and register writes it observes, and compares. Depends on tapid_pkg.
module tapid_checker #(
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  tapid_pkg::tapid_in_t          sample,
	input  logic                          drive_valid,
	input  logic                          drive_stall,
	input  tapid_pkg::tapid_out_t         drive,
	input  logic                          cfg_write,
	input  logic [tapid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tapid_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                            failures,
	output int                            pending,
	output int                            results_seen
);
	import tapid_pkg::*;

	localparam longint DEG      = longint'(1) << ANGLE_FRAC_BITS;
	localparam int     SHIFT    = GAIN_FRAC + ANGLE_FRAC_BITS;
	localparam longint ERR_HI   = (longint'(1) << (ERR_W - 1)) - 1;
	localparam longint ERR_LO   = -(longint'(1) << (ERR_W - 1));
	localparam longint MIN_MAG  = longint'(MIN_DRIVE);
	localparam longint FLOOR    = longint'(LIMIT_FLOOR);
	localparam longint INTEG_HI = 100 * DEG;

	// predictor copy of the registers and regulator state
	logic signed [ROT_W-1:0] turn_target;
	logic [SPD_W-1:0]        speed_cap;
	longint                  integ;
	longint                  prev_err;
	logic                    braking;

	tapid_out_t drive_q[$];
	tapid_out_t want;
	int         words_in;
	int         words_out;
	int         fail_count;

	assign failures     = fail_count;
	assign pending      = words_in - words_out;
	assign results_seen = words_out;

	// work out the drive word for one sample word and advance the state
	function automatic tapid_out_t regulate(input tapid_in_t w);
		longint setp, meas, err, mag, kp, limit, sum, ctl;
		tapid_out_t r;
		r = '0;
		if (w.action == ACT_START) begin
			integ    = 0;
			prev_err = 0;
			braking  = 1'b0;
			return r;
		end
		r.done_res = 1'b1;
		if (braking)
			return r;

		setp = -longint'($signed(turn_target));
		meas = w.rotation_valid ? longint'($signed(w.rotation)) : 0;

		// schedule gain and limit from the set point magnitude
		mag   = (setp < 0) ? -setp : setp;
		kp    = longint'(KP_BASE);
		limit = longint'(speed_cap);
		if (mag <= 45 * DEG || mag > 135 * DEG) begin
			kp    = (mag <= 45 * DEG) ? longint'(KP_NEAR) : longint'(KP_FAR);
			limit = longint'(speed_cap >> 1);
			if (limit < FLOOR)
				limit = FLOOR;
		end

		err = setp - meas;
		if (err > ERR_HI)
			err = ERR_HI;
		if (err < ERR_LO)
			err = ERR_LO;
		mag = (err < 0) ? -err : err;

		// within one degree: latch and brake
		if (mag < DEG) begin
			braking = 1'b1;
			return r;
		end
		r.done_res = 1'b0;

		// accumulate only near the set point, then clamp
		if (mag <= 20 * DEG)
			integ = integ + err;
		else
			integ = 0;
		if (integ > INTEG_HI)
			integ = INTEG_HI;
		if (integ < -INTEG_HI)
			integ = -INTEG_HI;

		sum = kp * err + longint'(KI_Q) * integ + longint'(KD_Q) * (err - prev_err);
		ctl = sum / (longint'(1) << SHIFT);
		if (((ctl < 0) ? -ctl : ctl) < MIN_MAG)
			ctl = (ctl > 0) ? MIN_MAG : -MIN_MAG;
		if (ctl > limit)
			ctl = limit;
		if (ctl < -limit)
			ctl = -limit;

		prev_err       = err;
		r.right_drive  = DRV_W'(ctl);
		r.left_drive   = DRV_W'(-ctl);
		return r;
	endfunction

	function automatic void flag_field(input string field, input int exp_v, input int got_v);
		fail_count = fail_count + 1;
		$display("%0t: %s mismatch, expected %0d got %0d", $time, field, exp_v, got_v);
	endfunction

	// track register writes, queue predictions, compare drive words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_target = '0;
			speed_cap   = MAX_SPEED_RST;
			integ       = 0;
			prev_err    = 0;
			braking     = 1'b0;
			drive_q.delete();
			words_in   <= 0;
			words_out  <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_TARGET_ANGLE: turn_target = cfg_data[ROT_W-1:0];
					REG_MAX_SPEED:    speed_cap   = cfg_data[SPD_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				drive_q.push_back(regulate(sample));
				words_in <= words_in + 1;
			end
			if (drive_valid && !drive_stall) begin
				words_out <= words_out + 1;
				if (drive_q.size() == 0) begin
					fail_count = fail_count + 1;
					$display("%0t: drive word with nothing expected, got %0d %0d %0d",
						$time, $signed(drive.left_drive), $signed(drive.right_drive),
						drive.done_res);
				end else begin
					want = drive_q.pop_front();
					if (drive.left_drive !== want.left_drive)
						flag_field("left_drive", int'($signed(want.left_drive)),
							int'($signed(drive.left_drive)));
					if (drive.right_drive !== want.right_drive)
						flag_field("right_drive", int'($signed(want.right_drive)),
							int'($signed(drive.right_drive)));
					if (drive.done_res !== want.done_res)
						flag_field("done_res", int'(want.done_res), int'(drive.done_res));
				end
			end
		end
	end

	initial begin
		fail_count = 0;
	end

endmodule

[tb/tb_turn_angle_pid.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the turn angle PID regulator: directed corner words, then
// randomised turn sequences under several register settings. Depends on tapid_pkg, tapid_checker.
module tb_turn_angle_pid;
	import tapid_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int ROT_HI      = (1 << (ROT_W - 1)) - 1;
	localparam int ROT_LO      = -(1 << (ROT_W - 1));

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	tapid_in_t             sample       = '0;
	logic                  drive_stall  = 1'b0;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  sample_stall;
	logic                  drive_valid;
	tapid_out_t            drive;

	int failures;
	int pending;
	int results_seen;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int words_sent     = 0;
	int settings_used  = 0;
	int quiet_cycles   = 0;
	int aim            = 0;

	always #5 clk = ~clk;

	turn_angle_pid uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive        (drive),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	tapid_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive        (drive),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// randomly hold off drive words
	always @(posedge clk)
		drive_stall <= ($urandom_range(99) < recv_stall_pct);

	// stop the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (drive_valid && !drive_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("turn_angle_pid test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one sample word, with random idle cycles ahead of it
	task automatic send_word(input logic act, input int rot, input logic rvalid);
		tapid_in_t w;
		if (rot > ROT_HI)
			rot = ROT_HI;
		if (rot < ROT_LO)
			rot = ROT_LO;
		w.action         = act;
		w.rotation       = rot[ROT_W-1:0];
		w.rotation_valid = rvalid;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample       <= w;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// hold the sender until every drive word is back
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// write both registers back to back
	task automatic set_regs(input int tgt, input int spd);
		cfg_write <= 1'b1;
		cfg_index <= REG_TARGET_ANGLE;
		cfg_data  <= tgt[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= REG_MAX_SPEED;
		cfg_data  <= CFG_DATA_W'(spd & 32'h7f);
		@(posedge clk);
		cfg_write <= 1'b0;
		aim = tgt;
		settings_used++;
	endtask

	// turns towards the set point: a start, then samples closing in with jitter
	task automatic random_turns(input int count);
		int n, len, k, setp, rot;
		logic ok;
		n    = 0;
		setp = -aim;
		while (n < count) begin
			if ($urandom_range(99) < 15) begin
				// stray word: any action, any reading
				send_word(1'($urandom_range(1)), int'($urandom), 1'($urandom_range(1)));
				n++;
			end else begin
				send_word(ACT_START, int'($urandom), 1'($urandom_range(1)));
				n++;
				len = $urandom_range(2, 16);
				for (k = 1; k <= len + int'($urandom_range(4)) && n < count; k++) begin
					rot = (k >= len) ? setp : setp * k / len;
					case ($urandom_range(3))
						0: rot = rot + int'($urandom_range(30)) - 15;
						1: rot = rot + int'($urandom_range(640)) - 320;
						2: rot = rot + int'($urandom_range(4000)) - 2000;
						default: ;
					endcase
					ok = ($urandom_range(11) != 0);
					if (!ok)
						rot = int'($urandom);
					send_word(ACT_SAMPLE, rot, ok);
					n++;
				end
			end
		end
	endtask

	task automatic run_setting(input int tgt, input int spd, input int count);
		drain();
		set_regs(tgt, spd);
		random_turns(count);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 26;
		recv_stall_pct = 73;

		// reset registers: set point zero, near gain
		send_word(ACT_START, 0, 1'b0);
		send_word(ACT_SAMPLE, -64, 1'b1);
		send_word(ACT_SAMPLE, -16, 1'b1);     // control truncates to zero
		send_word(ACT_SAMPLE, 320, 1'b1);     // exactly twenty degrees
		send_word(ACT_SAMPLE, 321, 1'b1);     // just above, integral drops
		send_word(ACT_SAMPLE, 16, 1'b1);      // exactly one degree off
		send_word(ACT_SAMPLE, 15, 1'b1);      // within one degree, brake
		send_word(ACT_SAMPLE, ROT_HI, 1'b1);  // sample while braking
		send_word(ACT_START, ROT_LO, 1'b0);
		send_word(ACT_SAMPLE, ROT_HI, 1'b0);  // bad reading taken as zero
		send_word(ACT_START, 0, 1'b1);
		send_word(ACT_SAMPLE, ROT_LO, 1'b1);
		send_word(ACT_SAMPLE, ROT_HI, 1'b1);

		// most negative target: error saturates
		drain();
		set_regs(ROT_LO, 127);
		send_word(ACT_START, 0, 1'b1);
		send_word(ACT_SAMPLE, ROT_LO, 1'b1);
		send_word(ACT_SAMPLE, 0, 1'b0);
		send_word(ACT_SAMPLE, ROT_HI, 1'b1);

		// base gain with a limit below the minimum drive; integral clamps
		drain();
		set_regs(1000, 5);
		send_word(ACT_START, 0, 1'b1);
		repeat (6)
			send_word(ACT_SAMPLE, -700, 1'b1);

		// zero limit gives zero drive
		drain();
		set_regs(-2160, 0);
		send_word(ACT_START, 0, 1'b1);
		send_word(ACT_SAMPLE, 0, 1'b1);
		send_word(ACT_SAMPLE, 1900, 1'b1);

		// sender mostly busy, receiver mostly stalled
		run_setting(720, 127, 90);
		run_setting(-721, 100, 90);
		run_setting(2161, 64, 90);
		run_setting(int'($urandom_range(4000)) - 2000, int'($urandom_range(127)), 90);

		// the other way round
		drain();
		send_idle_pct  = 73;
		recv_stall_pct = 26;
		run_setting(-2161, 20, 90);
		run_setting(ROT_HI, 127, 90);
		run_setting(ROT_LO, 9, 90);
		run_setting(int'($urandom_range(4000)) - 2000, int'($urandom_range(127)), 90);

		// full rate both ways
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_setting(1000, 0, 90);
		run_setting(0, 127, 90);
		run_setting(int'($urandom), int'($urandom_range(127)), 90);

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d sample words, checked %0d drive words over %0d register settings,",
			words_sent, results_seen, settings_used);
		$display("with idle and stall mixes 26/73, 73/26 and full rate.");
		if (failures == 0)
			$display("turn_angle_pid test passed");
		else
			$display("turn_angle_pid test failed");
		$finish;
	end

endmodule

[files.f]
design/tapid_pkg.sv
design/tapid_err_stage.sv
design/tapid_drive_stage.sv
design/turn_angle_pid.sv
tb/tapid_checker.sv
tb/tb_turn_angle_pid.sv
